[src/sic_pkg.sv]
// shared widths, constants and slot types of the spiral cell locator
`timescale 1ns / 1ps

package sic_pkg;

  // number and register width
  localparam int unsigned NumW   = 62;
  // square root resolves one bit per cell
  localparam int unsigned RootW  = NumW / 2;
  // partial remainder never exceeds twice the partial root
  localparam int unsigned RemW   = RootW + 2;
  // difference of two numbers, with room for the sign
  localparam int unsigned DiffW  = NumW + 2;
  // signed width for ring offset and coordinate arithmetic
  localparam int unsigned CalcW  = RootW + 4;
  // coordinate width on the output
  localparam int unsigned CoordW = 32;

  // origin number after reset
  localparam logic [NumW-1:0] StartReset = NumW'(1);

  // one item travelling through the square root cells
  typedef struct packed {
    logic             pos;   // offset is at least one
    logic [NumW-1:0]  rad;   // radicand bits not yet consumed, msb first
    logic [RemW-1:0]  rem;   // partial remainder
    logic [RootW-1:0] root;  // partial root
  } sqrt_slot_t;

  // ring index and side offset of one item
  typedef struct packed {
    logic                    pos;
    logic [RootW-1:0]        ring;
    logic signed [CalcW-1:0] offs;
  } ring_t;

endpackage

[src/sic_sqrt_cell.sv]
// one square root cell: resolves one root bit and hands the item on
`timescale 1ns / 1ps

module sic_sqrt_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  sic_pkg::sqrt_slot_t   in_slot_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output sic_pkg::sqrt_slot_t   out_slot_o
);

  logic                          valid_q;
  sic_pkg::sqrt_slot_t           slot_q, slot_d;
  logic [sic_pkg::RemW+1:0]      rem_sh;
  logic [sic_pkg::RemW+1:0]      trial;
  logic [sic_pkg::RemW+1:0]      rem_sub;

  // bring down two radicand bits and try the next root bit
  always_comb begin
    rem_sh  = {in_slot_i.rem, in_slot_i.rad[sic_pkg::NumW-1 -: 2]};
    trial   = {2'b00, in_slot_i.root, 2'b01};
    rem_sub = rem_sh - trial;
    slot_d      = in_slot_i;
    slot_d.rad  = {in_slot_i.rad[sic_pkg::NumW-3:0], 2'b00};
    if (rem_sh >= trial) begin
      slot_d.rem  = rem_sub[sic_pkg::RemW-1:0];
      slot_d.root = {in_slot_i.root[sic_pkg::RootW-2:0], 1'b1};
    end else begin
      slot_d.rem  = rem_sh[sic_pkg::RemW-1:0];
      slot_d.root = {in_slot_i.root[sic_pkg::RootW-2:0], 1'b0};
    end
  end

  // stage takes a new item when empty or when its content moves on
  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_slot_o  = slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      slot_q <= slot_d;
    end
  end

endmodule

[src/sic_place.sv]
// ring and side offset from the root, then the cell coordinates
`timescale 1ns / 1ps

module sic_place (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  sic_pkg::sqrt_slot_t                in_slot_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [sic_pkg::CoordW-1:0]         cell_x_o,
  output logic [sic_pkg::CoordW-1:0]         cell_y_o,
  output logic                               valid_res_o
);

  localparam logic signed [sic_pkg::CalcW-1:0] One = sic_pkg::CalcW'(1);
  localparam logic signed [sic_pkg::CalcW-1:0] Two = sic_pkg::CalcW'(2);

  logic                              mid_valid_q;
  logic                              mid_ready;
  sic_pkg::ring_t                    mid_q, mid_d;
  logic [sic_pkg::RootW:0]           ring_sum;
  logic signed [sic_pkg::CalcW-1:0]  rem_x, root_x2;

  logic                              out_valid_q;
  logic [sic_pkg::CoordW-1:0]        x_q, y_q, x_d, y_d;
  logic                              pos_q;
  logic signed [sic_pkg::CalcW-1:0]  a_s, a2_s, a3_s, d_s, x_s, y_s;

  // ring a = (root + 1) / 2; offset d = m - 4a^2 from root and remainder
  always_comb begin
    ring_sum  = {1'b0, in_slot_i.root} + {{sic_pkg::RootW{1'b0}}, 1'b1};
    rem_x     = sic_pkg::CalcW'(in_slot_i.rem);
    root_x2   = sic_pkg::CalcW'({in_slot_i.root, 1'b0});
    mid_d.pos  = in_slot_i.pos;
    mid_d.ring = ring_sum[sic_pkg::RootW:1];
    // odd root: 4a^2 = (root + 1)^2; even root: 4a^2 = root^2
    if (in_slot_i.root[0]) begin
      mid_d.offs = rem_x - root_x2;
    end else begin
      mid_d.offs = rem_x + One;
    end
  end

  assign in_ready_o = !mid_valid_q || mid_ready;
  assign mid_ready  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      mid_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      mid_q <= mid_d;
    end
  end

  // side of the ring selects the coordinate formulas
  always_comb begin
    a_s  = sic_pkg::CalcW'(mid_q.ring);
    a2_s = a_s <<< 1;
    a3_s = a_s + a2_s;
    d_s  = mid_q.offs;
    priority if (d_s < Two - a2_s) begin
      x_s = One - a3_s - d_s;
      y_s = a_s;
    end else if (d_s <= 0) begin
      x_s = -a_s;
      y_s = One - a_s - d_s;
    end else if (d_s <= a2_s) begin
      x_s = d_s - a_s - One;
      y_s = -a_s;
    end else begin
      x_s = a_s;
      y_s = d_s - a3_s - One;
    end
    if (mid_q.pos) begin
      x_d = x_s[sic_pkg::CoordW-1:0];
      y_d = y_s[sic_pkg::CoordW-1:0];
    end else begin
      x_d = '0;
      y_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (mid_ready) begin
      out_valid_q <= mid_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mid_valid_q && mid_ready) begin
      x_q   <= x_d;
      y_q   <= y_d;
      pos_q <= mid_q.pos;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cell_x_o    = x_q;
  assign cell_y_o    = y_q;
  assign valid_res_o = pos_q;

endmodule

[src/spiral_index_to_coordinates.sv]
// top level of the square spiral cell locator
`timescale 1ns / 1ps

// Maps a signed 62-bit number to its (x, y) cell on a square spiral whose
// origin holds start_number. One number is accepted per clock cycle unless
// stalled. A front register forms the offset from the origin, 31 square
// root cells resolve one root bit each, and sic_place forms ring, side and
// coordinates. A stall on the output side stops only the stages that hold
// items, so empty stages still take new numbers. Numbers below the origin
// give valid_res 0 and cell (0, 0). start_number resets to 1; the user must
// write it via the cfg channel only while idle; the block does not check it.
module spiral_index_to_coordinates (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [61:0] spiral_number, [63:62] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [31:0] cell_x, [63:32] cell_y
  output logic [0:0]  m_axis_tuser,   // [0] valid_res
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [61:0] cfg_data_i      // [61:0] start_number
);

  localparam int unsigned Cells = sic_pkg::RootW;

  logic [sic_pkg::NumW-1:0]   start_q;
  logic [sic_pkg::DiffW-1:0]  diff;
  logic                       front_valid_q;
  sic_pkg::sqrt_slot_t        front_q, front_d;

  sic_pkg::sqrt_slot_t        slot [Cells+1];
  logic [Cells:0]             slot_valid;
  logic [Cells:0]             slot_ready;

  logic [sic_pkg::CoordW-1:0] cell_x, cell_y;
  logic                       valid_res;

  // origin register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= sic_pkg::StartReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      start_q <= cfg_data_i;
    end
  end

  // offset from the origin: m - 1 = number - start
  always_comb begin
    diff = {{2{s_axis_tdata[sic_pkg::NumW-1]}}, s_axis_tdata[sic_pkg::NumW-1:0]}
         - {{2{start_q[sic_pkg::NumW-1]}}, start_q};
    front_d.pos  = !diff[sic_pkg::DiffW-1];
    front_d.rad  = diff[sic_pkg::NumW-1:0];
    front_d.rem  = '0;
    front_d.root = '0;
  end

  assign s_axis_tready = !front_valid_q || slot_ready[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      front_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      front_q <= front_d;
    end
  end

  assign slot[0]       = front_q;
  assign slot_valid[0] = front_valid_q;

  // row of square root cells
  for (genvar i = 0; i < Cells; i++) begin : g_cell
    sic_sqrt_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (slot_valid[i]),
      .in_ready_o  (slot_ready[i]),
      .in_slot_i   (slot[i]),
      .out_valid_o (slot_valid[i+1]),
      .out_ready_i (slot_ready[i+1]),
      .out_slot_o  (slot[i+1])
    );
  end

  // ring, side and coordinates
  sic_place u_place (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (slot_valid[Cells]),
    .in_ready_o  (slot_ready[Cells]),
    .in_slot_i   (slot[Cells]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cell_x_o    (cell_x),
    .cell_y_o    (cell_y),
    .valid_res_o (valid_res)
  );

  assign m_axis_tdata = {cell_y, cell_x};
  assign m_axis_tuser = valid_res;

`ifndef NO_ASSERTIONS
  localparam logic signed [31:0] CoordLim = 32'sd1073741825;

  // the number at the origin enters with a zero offset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tdata[sic_pkg::NumW-1:0] == start_q)
    |=> (front_valid_q && front_q.pos && front_q.rad == '0))
    else $error("origin number did not give a zero offset");

  // finished square root leaves a remainder of at most twice the root
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (slot_valid[Cells] && slot[Cells].pos)
    |-> (slot[Cells].rem <= {1'b0, slot[Cells].root, 1'b0}))
    else $error("square root remainder out of bound");

  // a result below the origin carries the zero cell
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("invalid result with nonzero coordinates");

  // coordinates stay within the reachable ring
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[31:0]) <= CoordLim
                       && $signed(m_axis_tdata[31:0]) >= -CoordLim
                       && $signed(m_axis_tdata[63:32]) <= CoordLim
                       && $signed(m_axis_tdata[63:32]) >= -CoordLim))
    else $error("coordinate outside the reachable range");
`endif

endmodule

[sim/spiral_index_to_coordinates_test.sv]
// self-checking testbench for the square spiral cell locator
`timescale 1ns / 1ps

module spiral_index_to_coordinates_test;

  localparam int unsigned     NumW       = sic_pkg::NumW;
  localparam int unsigned     CoordW     = sic_pkg::CoordW;
  localparam logic [NumW-1:0] StartReset = sic_pkg::StartReset;

  // expected outcome of one number
  typedef struct packed {
    logic signed [CoordW-1:0] cell_x;
    logic signed [CoordW-1:0] cell_y;
    logic                     valid_res;
  } cell_t;

  localparam logic [NumW-1:0] NumMax = {1'b0, {(NumW-1){1'b1}}};
  localparam logic [NumW-1:0] NumMin = {1'b1, {(NumW-1){1'b0}}};
  localparam int unsigned TailCycles = 40;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // [61:0] spiral_number, [63:62] zero
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;        // [31:0] cell_x, [63:32] cell_y
  logic [0:0]  m_axis_tuser;        // [0] valid_res
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [61:0] cfg_data_i = '0;     // [61:0] start_number

  // numbers waiting to be sent, cells waiting to come back
  logic [NumW-1:0] pending_numbers[$];
  cell_t           expected_cells[$];

  logic [NumW-1:0] origin_now = StartReset;   // origin as the block should hold it
  logic [NumW-1:0] origin_set = StartReset;   // origin as the stimulus last wrote it
  logic            number_taken = 1'b0;
  int unsigned     send_idle_pct = 0;
  int unsigned     recv_stall_pct = 0;
  int unsigned     mismatch_count = 0;
  int unsigned     numbers_taken = 0;
  int unsigned     cells_checked = 0;
  int unsigned     off_spiral_count = 0;
  int unsigned     origin_writes = 0;

  spiral_index_to_coordinates dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // exact floor square root, two bits of radicand per step
  function automatic longint unsigned floor_root(input longint unsigned radicand);
    longint unsigned root;
    longint unsigned probe;
    root  = 0;
    probe = 64'd1 << 62;
    while (probe > radicand) probe >>= 2;
    while (probe != 0) begin
      if (radicand >= root + probe) begin
        radicand -= root + probe;
        root = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  // spiral cell of a number for a given origin
  function automatic cell_t locate_cell(input logic [NumW-1:0] number,
                                        input logic [NumW-1:0] origin);
    longint offs, ring, side, x, y;
    cell_t  found;
    found = '0;
    offs = longint'($signed(number)) - longint'($signed(origin)) + 1;
    if (offs >= 1) begin
      ring = (longint'(floor_root(longint'(offs - 1))) + 1) / 2;
      side = offs - 4 * ring * ring;
      if (side < 2 - 2 * ring) begin
        // top side
        x = 1 - 3 * ring - side;
        y = ring;
      end else if (side <= 0) begin
        // left side
        x = -ring;
        y = 1 - ring - side;
      end else if (side <= 2 * ring) begin
        // bottom side
        x = side - ring - 1;
        y = -ring;
      end else begin
        // right side
        x = ring;
        y = side - 3 * ring - 1;
      end
      found.cell_x    = x[CoordW-1:0];
      found.cell_y    = y[CoordW-1:0];
      found.valid_res = 1'b1;
    end
    return found;
  endfunction

  // number whose offset from the origin lands in an interesting place
  function automatic logic [NumW-1:0] pick_number(input logic [NumW-1:0] origin);
    longint      offs, ring, side;
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 10) return NumW'({$urandom, $urandom});
    if (sel < 25) begin
      // offset below one
      offs = -longint'($urandom_range(40));
    end else if (sel < 60) begin
      // offset of random magnitude
      offs = longint'({$urandom, $urandom} >> (64 - $urandom_range(62, 1)));
      if (offs == 0) offs = 1;
    end else begin
      // near a corner of a ring
      ring = longint'({$urandom, $urandom} >> (64 - $urandom_range(30, 1)));
      if (ring == 0) ring = 1;
      case ($urandom_range(7))
        0: side = 1 - 2 * ring;
        1: side = 2 - 2 * ring;
        2: side = 0;
        3: side = 1;
        4: side = 2 * ring;
        5: side = 2 * ring + 1;
        6: side = 2 - 4 * ring;
        default: side = 4 * ring + 1;
      endcase
      offs = 4 * ring * ring + side + longint'($urandom_range(2)) - 1;
    end
    return NumW'(offs + longint'($signed(origin)) - 1);
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("%0t ns: mismatch: %s", $time, what);
  endtask

  // input transfers, output transfers and register writes, all seen at the rising edge
  always @(posedge clk_i) begin
    cell_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) origin_now = cfg_data_i;
      if (m_axis_tvalid && m_axis_tready) begin
        cells_checked++;
        if (!m_axis_tuser[0]) off_spiral_count++;
        if (expected_cells.size() == 0) begin
          report_mismatch($sformatf("cell transfer with nothing expected, data %h user %b",
                                    m_axis_tdata, m_axis_tuser));
        end else begin
          want = expected_cells.pop_front();
          if (m_axis_tdata[31:0] !== want.cell_x)
            report_mismatch($sformatf("cell_x %0d, expected %0d",
                                      $signed(m_axis_tdata[31:0]), want.cell_x));
          if (m_axis_tdata[63:32] !== want.cell_y)
            report_mismatch($sformatf("cell_y %0d, expected %0d",
                                      $signed(m_axis_tdata[63:32]), want.cell_y));
          if (m_axis_tuser[0] !== want.valid_res)
            report_mismatch($sformatf("valid_res %b, expected %b",
                                      m_axis_tuser[0], want.valid_res));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_cells.push_back(locate_cell(s_axis_tdata[NumW-1:0], origin_now));
        numbers_taken++;
      end
    end
    number_taken <= s_axis_tvalid && s_axis_tready;
  end

  // number sender and result receiver, driven on the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || number_taken) begin
        if (pending_numbers.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {2'b00, pending_numbers.pop_front()};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // wait until no number is queued or in flight
  task automatic drain();
    @(negedge clk_i);
    while (pending_numbers.size() != 0 || s_axis_tvalid || expected_cells.size() != 0)
      @(negedge clk_i);
  endtask

  // register write while the block is idle
  task automatic write_origin(input logic [NumW-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    origin_set = value;
    origin_writes++;
  endtask

  // start a phase: set idling and queue random numbers
  task automatic queue_phase(input int unsigned send_idle, input int unsigned recv_stall,
                             input int unsigned count);
    @(posedge clk_i);
    send_idle_pct  = send_idle;
    recv_stall_pct = recv_stall;
    repeat (count) pending_numbers.push_back(pick_number(origin_set));
  endtask

  // stimulus sequence
  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset origin: corners of the first rings, extremes, offsets below one
    @(posedge clk_i);
    pending_numbers = '{NumW'(1), NumW'(0), '1, NumW'(2), NumW'(3), NumW'(4), NumW'(5),
                        NumW'(6), NumW'(7), NumW'(8), NumW'(9), NumW'(10), NumW'(25),
                        NumW'(26), NumW'(49), NumW'(50), NumMax, NumMin,
                        NumW'(64'd1 << 60), NumW'(-(64'd1 << 30))};
    drain();

    // lowest origin: largest offset and origin cell, sender idling
    write_origin(NumMin);
    @(posedge clk_i);
    pending_numbers = '{NumMax, NumMin, NumMin + NumW'(1)};
    queue_phase(68, 0, 240);
    drain();

    // highest origin: smallest offset, receiver stalling
    write_origin(NumMax);
    @(posedge clk_i);
    pending_numbers = '{NumMin, NumMax, NumMax - NumW'(1)};
    queue_phase(0, 68, 240);
    drain();

    // random origin, both sides idling
    write_origin(NumW'({$urandom, $urandom}));
    queue_phase(14, 14, 250);
    drain();

    // zero origin, no idling
    write_origin('0);
    queue_phase(0, 0, 250);
    drain();

    repeat (TailCycles) @(negedge clk_i);
    $display("checked %0d cells for %0d numbers across %0d origin writes and reset origin",
             cells_checked, numbers_taken, origin_writes);
    $display("%0d of them off the spiral, idling phases: none, sender, receiver, both",
             off_spiral_count);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
